// File: hw/rtl/isolated_riser_profile_meter_defines.svh
// ----------------------------------------------------------------------------
// Isolated riser profile meter: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef ISOLATED_RISER_PROFILE_METER_DEFINES_SVH
`define ISOLATED_RISER_PROFILE_METER_DEFINES_SVH

// Condition holds at every edge outside reset.
`define IRPM_ASSERT_NOW(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition holds at the next edge after the trigger.
`define IRPM_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// File: hw/rtl/irpm_pkg.sv
// ----------------------------------------------------------------------------
// irpm_pkg
// Types and fixed widths shared by the isolated riser profile meter.
// ----------------------------------------------------------------------------
package irpm_pkg;

    localparam int RISE_W     = 37;
    localparam int COUNT_W    = 21;
    localparam int CFG_W      = 16;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;
    localparam int FRAC_W     = 16;
    localparam int TOTAL_LO_W = 32;
    localparam int TOTAL_HI_W = RISE_W - TOTAL_LO_W;
    localparam int PLO_W      = CFG_W + TOTAL_LO_W;
    localparam int PHI_W      = CFG_W + TOTAL_HI_W;
    localparam int PROD_W     = RISE_W + FRAC_W;

    localparam logic [RISE_W-1:0]  RISE_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        ST_PASS    = 2'd0,
        ST_FLAT    = 2'd1,
        ST_STEPPED = 2'd2
    } t_status;

    typedef enum logic [0:0] {
        REG_MIN_STEP = 1'b0,
        REG_MAX_FRAC = 1'b1
    } t_reg_idx;

    // Per-item event from the line tracker.
    typedef struct packed {
        logic iso;
        logic sub;
        logic report;
    } t_line_evt;

    // Region totals handed to the judge stage.
    typedef struct packed {
        logic [RISE_W-1:0]  total;
        logic [RISE_W-1:0]  stepped;
        logic [COUNT_W-1:0] iso;
        logic [COUNT_W-1:0] sub;
    } t_totals;

endpackage

// File: hw/rtl/irpm_line.sv
// ----------------------------------------------------------------------------
// irpm_line
// Input register and per-line delta tracking; classifies isolated risers.
// ----------------------------------------------------------------------------
module irpm_line #(
    parameter int HEIGHT_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [HEIGHT_BITS-1:0]          i_height,
    input  logic                            i_end_of_line,
    input  logic                            i_end_of_region,
    input  logic [irpm_pkg::CFG_W-1:0]      i_min_step,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [HEIGHT_BITS-1:0]          o_rise_mag,
    output logic [HEIGHT_BITS-1:0]          o_step_mag,
    output irpm_pkg::t_line_evt             o_evt
);

    localparam int CMP_W = (HEIGHT_BITS > irpm_pkg::CFG_W) ? HEIGHT_BITS : irpm_pkg::CFG_W;

    logic                   r_v;
    logic [HEIGHT_BITS-1:0] r_height;
    logic                   r_eol;
    logic                   r_eor;

    logic [HEIGHT_BITS-1:0] r_prev,  n_prev;
    logic                   r_have,  n_have;
    logic [HEIGHT_BITS-1:0] r_pmag,  n_pmag;
    logic                   r_pval,  n_pval;
    logic                   r_pflat, n_pflat;

    logic                   go;
    logic                   nz;
    logic [HEIGHT_BITS-1:0] d_mag;
    logic                   settle_old;
    logic                   settle_new;
    logic                   below;

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;
    assign go      = r_v && i_ready;

    assign nz    = r_have && (r_height != r_prev);
    assign d_mag = (r_height >= r_prev) ? (r_height - r_prev) : (r_prev - r_height);

    // pending riser closes on a flat delta; a fresh riser closes at line edge
    assign settle_old = r_have && !nz && r_pval && r_pflat;
    assign settle_new = r_eol && nz && !r_pval;

    assign o_step_mag = settle_old ? r_pmag : d_mag;
    assign o_rise_mag = nz ? d_mag : '0;
    assign below      = CMP_W'(o_step_mag) < CMP_W'(i_min_step);

    always_comb begin
        o_evt.iso    = (settle_old || settle_new) && !below;
        o_evt.sub    = (settle_old || settle_new) && below;
        o_evt.report = r_eol && r_eor;
    end

    always_comb begin
        n_prev  = r_prev;
        n_have  = r_have;
        n_pmag  = r_pmag;
        n_pval  = r_pval;
        n_pflat = r_pflat;
        if (r_eol) begin
            n_prev  = '0;
            n_have  = 1'b0;
            n_pmag  = '0;
            n_pval  = 1'b0;
            n_pflat = 1'b1;
        end else begin
            n_prev = r_height;
            n_have = 1'b1;
            if (r_have) begin
                n_pval = nz;
                if (nz) begin
                    n_pmag  = d_mag;
                    n_pflat = !r_pval;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= 1'b0;
            r_prev  <= '0;
            r_have  <= 1'b0;
            r_pmag  <= '0;
            r_pval  <= 1'b0;
            r_pflat <= 1'b1;
        end else begin
            if (o_ready) begin
                r_v <= i_valid;
            end
            if (go) begin
                r_prev  <= n_prev;
                r_have  <= n_have;
                r_pmag  <= n_pmag;
                r_pval  <= n_pval;
                r_pflat <= n_pflat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_height <= i_height;
            r_eol    <= i_end_of_line;
            r_eor    <= i_end_of_region;
        end
    end

endmodule

// File: hw/rtl/irpm_accum.sv
// ----------------------------------------------------------------------------
// irpm_accum
// Event register, saturating region accumulators and report snapshot.
// ----------------------------------------------------------------------------
module irpm_accum #(
    parameter int HEIGHT_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [HEIGHT_BITS-1:0] i_rise_mag,
    input  logic [HEIGHT_BITS-1:0] i_step_mag,
    input  irpm_pkg::t_line_evt    i_evt,
    output logic                   o_valid,
    input  logic                   i_ready,
    output irpm_pkg::t_totals      o_totals
);

    localparam int RW = irpm_pkg::RISE_W;

    logic                   r_v;
    logic [HEIGHT_BITS-1:0] r_rise_mag;
    logic [HEIGHT_BITS-1:0] r_step_mag;
    irpm_pkg::t_line_evt    r_evt;

    irpm_pkg::t_totals      r_acc, n_acc;
    logic                   r_snap_v;
    irpm_pkg::t_totals      r_snap;

    logic                   load_snap;
    logic                   go;
    logic [RW:0]            sum_total;
    logic [RW:0]            sum_stepped;

    assign load_snap = !r_snap_v || i_ready;
    assign go        = r_v && (!r_evt.report || load_snap);
    assign o_ready   = !r_v || go;
    assign o_valid   = r_snap_v;
    assign o_totals  = r_snap;

    assign sum_total   = {1'b0, r_acc.total}   + (RW + 1)'(r_rise_mag);
    assign sum_stepped = {1'b0, r_acc.stepped} + (RW + 1)'(r_step_mag);

    always_comb begin
        n_acc = r_acc;
        n_acc.total = sum_total[RW] ? irpm_pkg::RISE_MAX : sum_total[RW-1:0];
        if (r_evt.iso) begin
            n_acc.stepped = sum_stepped[RW] ? irpm_pkg::RISE_MAX : sum_stepped[RW-1:0];
            if (r_acc.iso != irpm_pkg::COUNT_MAX) begin
                n_acc.iso = r_acc.iso + 1'b1;
            end
        end
        if (r_evt.sub && (r_acc.sub != irpm_pkg::COUNT_MAX)) begin
            n_acc.sub = r_acc.sub + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v      <= 1'b0;
            r_acc    <= '0;
            r_snap_v <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v <= i_valid;
            end
            if (go) begin
                r_acc <= r_evt.report ? '0 : n_acc;
            end
            if (load_snap) begin
                r_snap_v <= go && r_evt.report;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_rise_mag <= i_rise_mag;
            r_step_mag <= i_step_mag;
            r_evt      <= i_evt;
        end
        if (go && r_evt.report) begin
            r_snap <= n_acc;
        end
    end

endmodule

// File: hw/rtl/irpm_judge.sv
// ----------------------------------------------------------------------------
// irpm_judge
// Cross-multiplied ratio check, status decode and result register.
// ----------------------------------------------------------------------------
module irpm_judge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  irpm_pkg::t_totals             i_totals,
    input  logic [irpm_pkg::CFG_W-1:0]    i_max_frac,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_status,
    output logic [irpm_pkg::RISE_W-1:0]   o_total_rise,
    output logic [irpm_pkg::RISE_W-1:0]   o_stepped_rise,
    output logic [irpm_pkg::COUNT_W-1:0]  o_isolated_steps,
    output logic [irpm_pkg::COUNT_W-1:0]  o_sub_threshold_steps
);

    // product stage
    logic                               r_v4;
    irpm_pkg::t_totals                  r_tot4;
    logic [irpm_pkg::PLO_W-1:0]         r_plo;
    logic [irpm_pkg::PHI_W-1:0]         r_phi;
    // result stage
    logic                               r_v5;
    irpm_pkg::t_totals                  r_tot5;
    irpm_pkg::t_status                  r_status, n_status;

    logic                               load4;
    logic                               load5;
    logic [irpm_pkg::PLO_W-1:0]         plo;
    logic [irpm_pkg::PHI_W-1:0]         phi;
    logic [irpm_pkg::PROD_W-1:0]        bar_prod;
    logic [irpm_pkg::PROD_W-1:0]        stepped_scaled;

    assign load5   = !r_v5 || i_ready;
    assign load4   = !r_v4 || load5;
    assign o_ready = load4;

    // total split into 32 low bits and the 5 high bits
    assign plo = irpm_pkg::PLO_W'(i_max_frac)
               * irpm_pkg::PLO_W'(i_totals.total[irpm_pkg::TOTAL_LO_W-1:0]);
    assign phi = irpm_pkg::PHI_W'(i_max_frac)
               * irpm_pkg::PHI_W'(i_totals.total[irpm_pkg::RISE_W-1:irpm_pkg::TOTAL_LO_W]);

    assign bar_prod       = irpm_pkg::PROD_W'(r_plo)
                          + {r_phi, {irpm_pkg::TOTAL_LO_W{1'b0}}};
    assign stepped_scaled = {r_tot4.stepped, {irpm_pkg::FRAC_W{1'b0}}};

    always_comb begin
        if (r_tot4.total == '0) begin
            n_status = irpm_pkg::ST_FLAT;
        end else if (stepped_scaled > bar_prod) begin
            n_status = irpm_pkg::ST_STEPPED;
        end else begin
            n_status = irpm_pkg::ST_PASS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (load4) begin
                r_v4 <= i_valid;
            end
            if (load5) begin
                r_v5 <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && load4) begin
            r_tot4 <= i_totals;
            r_plo  <= plo;
            r_phi  <= phi;
        end
        if (r_v4 && load5) begin
            r_tot5   <= r_tot4;
            r_status <= n_status;
        end
    end

    assign o_valid               = r_v5;
    assign o_status              = r_status;
    assign o_total_rise          = r_tot5.total;
    assign o_stepped_rise        = r_tot5.stepped;
    assign o_isolated_steps      = r_tot5.iso;
    assign o_sub_threshold_steps = r_tot5.sub;

endmodule

// File: hw/rtl/isolated_riser_profile_meter.sv
// A result reaches o_out_valid after its closing item passes the input, event, snapshot, product and result registers.
// Throughput: one item per cycle while no waiting result backs up the pipe to the input.
// Items that give no result still take the same path and leave no output.
// Reset (i_rst_n low, synchronous): pipeline empty, line state cleared, accumulators
// zero, min_step_units = 1, max_step_fraction = 32768.
// ----------------------------------------------------------------------------
// isolated_riser_profile_meter
// Streams height samples line by line, sums rise, counts isolated and sub-threshold risers and
// reports totals plus a pass / flat / stepped status at the end of a region.
// ----------------------------------------------------------------------------
`include "isolated_riser_profile_meter_defines.svh"

module isolated_riser_profile_meter #(
    parameter int HEIGHT_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [HEIGHT_BITS-1:0]        i_height,
    input  logic                          i_end_of_line,
    input  logic                          i_end_of_region,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_status,
    output logic [irpm_pkg::RISE_W-1:0]   o_total_rise,
    output logic [irpm_pkg::RISE_W-1:0]   o_stepped_rise,
    output logic [irpm_pkg::COUNT_W-1:0]  o_isolated_steps,
    output logic [irpm_pkg::COUNT_W-1:0]  o_sub_threshold_steps,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [irpm_pkg::APB_AW-1:0]   paddr,
    input  logic [irpm_pkg::APB_DW-1:0]   pwdata,
    output logic [irpm_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    // ------------------------------------------------------------------
    // Configuration registers. Byte address 4*i, so paddr[2] picks one.
    // The user must write them only while no item is in flight; the block does not enforce it.
    // ------------------------------------------------------------------
    logic [irpm_pkg::CFG_W-1:0] r_min_step;
    logic [irpm_pkg::CFG_W-1:0] r_max_frac;
    irpm_pkg::t_reg_idx         reg_idx;
    logic                       cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = irpm_pkg::t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_step <= irpm_pkg::CFG_W'(1);
            r_max_frac <= irpm_pkg::CFG_W'(32768);
        end else if (cfg_wr) begin
            case (reg_idx)
                irpm_pkg::REG_MIN_STEP: begin
                    r_min_step <= pwdata[irpm_pkg::CFG_W-1:0];
                end
                irpm_pkg::REG_MAX_FRAC: begin
                    r_max_frac <= pwdata[irpm_pkg::CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read data follows the address, no wait states.
    always_comb begin
        case (reg_idx)
            irpm_pkg::REG_MIN_STEP: begin
                prdata = irpm_pkg::APB_DW'(r_min_step);
            end
            irpm_pkg::REG_MAX_FRAC: begin
                prdata = irpm_pkg::APB_DW'(r_max_frac);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath:
    //   line tracker  - input register, delta vs previous sample, pending
    //                   riser judgment (flat on both sides), threshold test
    //   accumulator   - event register, saturating sums and counters,
    //                   snapshot + clear on the region's last item
    //   judge         - bar * total (split 16x32 and 16x5 products), then
    //                   compare against stepped << 16, result register
    // Each stage takes a new item whenever it is empty or moving on, so a
    // waiting result does not block new samples until the pipe fills.
    // ------------------------------------------------------------------
    logic                       line_valid;
    logic                       line_ready;
    logic [HEIGHT_BITS-1:0]     line_rise_mag;
    logic [HEIGHT_BITS-1:0]     line_step_mag;
    irpm_pkg::t_line_evt        line_evt;

    logic                       acc_valid;
    logic                       acc_ready;
    irpm_pkg::t_totals          acc_totals;

    irpm_line #(
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_line (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in_valid),
        .o_ready         (o_in_ready),
        .i_height        (i_height),
        .i_end_of_line   (i_end_of_line),
        .i_end_of_region (i_end_of_region),
        .i_min_step      (r_min_step),
        .o_valid         (line_valid),
        .i_ready         (line_ready),
        .o_rise_mag      (line_rise_mag),
        .o_step_mag      (line_step_mag),
        .o_evt           (line_evt)
    );

    irpm_accum #(
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (line_valid),
        .o_ready    (line_ready),
        .i_rise_mag (line_rise_mag),
        .i_step_mag (line_step_mag),
        .i_evt      (line_evt),
        .o_valid    (acc_valid),
        .i_ready    (acc_ready),
        .o_totals   (acc_totals)
    );

    irpm_judge u_judge (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (acc_valid),
        .o_ready               (acc_ready),
        .i_totals              (acc_totals),
        .i_max_frac            (r_max_frac),
        .o_valid               (o_out_valid),
        .i_ready               (i_out_ready),
        .o_status              (o_status),
        .o_total_rise          (o_total_rise),
        .o_stepped_rise        (o_stepped_rise),
        .o_isolated_steps      (o_isolated_steps),
        .o_sub_threshold_steps (o_sub_threshold_steps)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // an empty result register means the whole pipe can move
    `IRPM_ASSERT_NOW(a_ready_when_out_empty, i_clk, i_rst_n, o_out_valid || o_in_ready, "input stalled with empty output")
    // flat exactly when nothing rose
    `IRPM_ASSERT_NOW(a_flat_iff_zero, i_clk, i_rst_n, !o_out_valid || ((o_status == irpm_pkg::ST_FLAT) == (o_total_rise == '0)), "flat status mismatch")
    // stepped rise is a part of the total rise
    `IRPM_ASSERT_NOW(a_stepped_le_total, i_clk, i_rst_n, !o_out_valid || (o_stepped_rise <= o_total_rise), "stepped rise exceeds total")
    // a min_step write reads back on the next cycle at the same address
    `IRPM_ASSERT_NEXT(a_min_step_readback, i_clk, i_rst_n, i_rst_n && cfg_wr && (reg_idx == irpm_pkg::REG_MIN_STEP), (paddr != $past(paddr)) || (prdata[15:0] == $past(pwdata[15:0])), "min step readback mismatch")

endmodule
